// ===== rtl/bxavg_pkg.sv =====
// Shared types and constants of the box average downscaler.
package bxavg_pkg;

  localparam int PIX_W    = 8;
  localparam int SUM_W    = 29;
  localparam int CNT_W    = 21;
  localparam int REM_W    = CNT_W + 1;
  localparam int IDX_W    = 21;
  localparam int WID_W    = 11;
  localparam int HGT_W    = 10;
  localparam int LANES    = 3;
  localparam int NUM_REGS = 7;
  localparam int ADDR_W   = 5;
  localparam int DATA_W   = 32;
  localparam int IN_W     = 24;
  localparam int OUT_W    = 48;

  // Register indexes
  localparam logic [2:0] REG_SRC_WIDTH   = 3'd0;
  localparam logic [2:0] REG_SRC_HEIGHT  = 3'd1;
  localparam logic [2:0] REG_DST_WIDTH   = 3'd2;
  localparam logic [2:0] REG_DST_HEIGHT  = 3'd3;
  localparam logic [2:0] REG_STRIDE      = 3'd4;
  localparam logic [2:0] REG_OFFSET_X    = 3'd5;
  localparam logic [2:0] REG_OFFSET_Y    = 3'd6;

  typedef struct packed {
    logic [SUM_W-1:0] red;
    logic [SUM_W-1:0] green;
    logic [SUM_W-1:0] blue;
    logic [CNT_W-1:0] count;
  } entry_t;

  typedef struct packed {
    logic accept;
    logic calc_write;
    logic avg_start;
    logic bnd_start;
    logic bnd_load;
    logic out_load;
    logic advance;
    logic clear_step;
  } cmd_t;

  typedef struct packed {
    logic cfg_wr;
    logic emit;
    logic col_close;
    logic div_busy;
    logic div_done;
    logic out_free;
    logic clear_last;
  } sts_t;

endpackage

// ===== rtl/box_average_downscaler_core.sv =====
// Top level of the box average downscaler.
//
//  port group   direction  word / contents
//  s_*          in         one source pixel, RGB888 raster order
//  m_*          out        one destination pixel with canvas index
//  APB          in/out     seven size and placement registers at 4*i
//
// A pixel that closes no destination column passes through accept, sum and advance.
// Closing a column adds a boundary pass on the serial divider;
// a pixel that also completes a destination pixel adds the averaging pass
// (a pass on the divider, then the load of the output word).
// The divider gives one bit per cycle.
// After reset and after every register write a clearing pass sweeps the column
// sum memory, then one boundary pass; s_tready stays low.
// A finished word waits in the output register; a stalled m_tready holds the
// controller only when the next destination pixel is ready to leave.
module box_average_downscaler_core
  import bxavg_pkg::*;
#(
  parameter int MAX_SRC_WIDTH  = 1280,
  parameter int MAX_SRC_HEIGHT = 960
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [IN_W-1:0]   s_tdata,   // in_red, in_green, in_blue
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [OUT_W-1:0]  m_tdata,   // canvas_index, out_red, out_green, out_blue, zero pad
  output logic              m_tlast,   // image_done
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  cmd_t cmd;
  sts_t sts;

  // register port never waits
  assign pready = 1'b1;

  bxavg_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  bxavg_datapath #(
    .MAX_SRC_WIDTH  (MAX_SRC_WIDTH),
    .MAX_SRC_HEIGHT (MAX_SRC_HEIGHT)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .sts      (sts),
    .s_tdata  (s_tdata),
    .m_tready (m_tready),
    .m_tvalid (m_tvalid),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata)
  );

endmodule

// ===== rtl/bxavg_div.sv =====
// Three-lane restoring divider, one quotient bit per cycle.
module bxavg_div
  import bxavg_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic [LANES-1:0][SUM_W-1:0] dividend,
  input  logic [LANES-1:0][CNT_W-1:0] divisor,
  output logic                    busy,
  output logic                    done,
  output logic [LANES-1:0][SUM_W-1:0] quotient
);

  localparam int STEP_W = $clog2(SUM_W + 1);

  logic [STEP_W-1:0]               steps;
  logic [LANES-1:0][REM_W-1:0]     rem;
  logic [LANES-1:0][CNT_W-1:0]     dsr;
  logic [LANES-1:0][REM_W-1:0]     shifted;
  logic [LANES-1:0]                fits;

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      shifted[l] = {rem[l][CNT_W-1:0], quotient[l][SUM_W-1]};
      fits[l]    = shifted[l] >= {1'b0, dsr[l]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        steps <= STEP_W'(SUM_W);
      end else if (busy) begin
        steps <= steps - STEP_W'(1);
        if (steps == STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      quotient <= dividend;
      dsr      <= divisor;
    end else if (busy) begin
      for (int l = 0; l < LANES; l++) begin
        rem[l]      <= fits[l] ? shifted[l] - {1'b0, dsr[l]} : shifted[l];
        quotient[l] <= {quotient[l][SUM_W-2:0], fits[l]};
      end
    end
  end

endmodule

// ===== rtl/bxavg_datapath.sv =====
// Datapath: registers, column sum memory, position counters, divider, output word.
module bxavg_datapath
  import bxavg_pkg::*;
#(
  parameter int MAX_SRC_WIDTH  = 1280,
  parameter int MAX_SRC_HEIGHT = 960
) (
  input  logic              clk,
  input  logic              rst,
  input  cmd_t              cmd,
  output sts_t              sts,
  input  logic [IN_W-1:0]   s_tdata,
  input  logic              m_tready,
  output logic              m_tvalid,
  output logic [OUT_W-1:0]  m_tdata,
  output logic              m_tlast,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata
);

  localparam int AW = $clog2(MAX_SRC_WIDTH);
  localparam logic [12:0] MAXW = 13'(MAX_SRC_WIDTH);
  localparam logic [12:0] MAXH = 13'(MAX_SRC_HEIGHT);

  // configuration
  logic [WID_W-1:0] src_width, dst_width, row_pitch, offset_x;
  logic [HGT_W-1:0] src_height, dst_height, offset_y;
  logic [2:0]       reg_sel;
  logic             cfg_wr;

  assign reg_sel = paddr[4:2];
  assign cfg_wr  = psel && penable && pwrite && (reg_sel < 3'(NUM_REGS));

  always_ff @(posedge clk) begin
    if (rst) begin
      src_width  <= WID_W'(1);
      src_height <= HGT_W'(1);
      dst_width  <= WID_W'(1);
      dst_height <= HGT_W'(1);
      row_pitch  <= WID_W'(1);
      offset_x   <= '0;
      offset_y   <= '0;
    end else if (cfg_wr) begin
      case (reg_sel)
        REG_SRC_WIDTH:  src_width  <= pwdata[WID_W-1:0];
        REG_SRC_HEIGHT: src_height <= pwdata[HGT_W-1:0];
        REG_DST_WIDTH:  dst_width  <= pwdata[WID_W-1:0];
        REG_DST_HEIGHT: dst_height <= pwdata[HGT_W-1:0];
        REG_STRIDE:     row_pitch  <= pwdata[WID_W-1:0];
        REG_OFFSET_X:   offset_x   <= pwdata[WID_W-1:0];
        REG_OFFSET_Y:   offset_y   <= pwdata[HGT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_SRC_WIDTH:  prdata = DATA_W'(src_width);
      REG_SRC_HEIGHT: prdata = DATA_W'(src_height);
      REG_DST_WIDTH:  prdata = DATA_W'(dst_width);
      REG_DST_HEIGHT: prdata = DATA_W'(dst_height);
      REG_STRIDE:     prdata = DATA_W'(row_pitch);
      REG_OFFSET_X:   prdata = DATA_W'(offset_x);
      REG_OFFSET_Y:   prdata = DATA_W'(offset_y);
      default:        prdata = '0;
    endcase
  end

  // effective sizes
  logic [WID_W-1:0] sw_e, dw_e;
  logic [HGT_W-1:0] sh_e, dh_e;

  always_comb begin
    if (src_width == '0)                sw_e = WID_W'(1);
    else if ({2'b0, src_width} > MAXW)  sw_e = MAXW[WID_W-1:0];
    else                                sw_e = src_width;
    if (src_height == '0)               sh_e = HGT_W'(1);
    else if ({3'b0, src_height} > MAXH) sh_e = MAXH[HGT_W-1:0];
    else                                sh_e = src_height;
    if (dst_width == '0)                dw_e = WID_W'(1);
    else if (dst_width > sw_e)          dw_e = sw_e;
    else                                dw_e = dst_width;
    if (dst_height == '0)               dh_e = HGT_W'(1);
    else if (dst_height > sh_e)         dh_e = sh_e;
    else                                dh_e = dst_height;
  end

  // positions
  logic [WID_W-1:0] src_col, out_col, col_end;
  logic [HGT_W-1:0] src_row, out_row, row_end;
  logic [WID_W:0]   src_col_inc, out_col_inc;
  logic [HGT_W:0]   src_row_inc, out_row_inc;
  logic             col_close, row_close, line_wrap, frame_wrap;

  assign src_col_inc = {1'b0, src_col} + (WID_W+1)'(1);
  assign out_col_inc = {1'b0, out_col} + (WID_W+1)'(1);
  assign src_row_inc = {1'b0, src_row} + (HGT_W+1)'(1);
  assign out_row_inc = {1'b0, out_row} + (HGT_W+1)'(1);
  assign col_close   = src_col_inc >= {1'b0, col_end};
  assign row_close   = src_row_inc >= {1'b0, row_end};
  assign line_wrap   = src_col_inc >= {1'b0, sw_e};
  assign frame_wrap  = src_row_inc >= {1'b0, sh_e};

  always_ff @(posedge clk) begin
    if (rst || cfg_wr) begin
      src_col <= '0;
      src_row <= '0;
      out_col <= '0;
      out_row <= '0;
    end else if (cmd.advance) begin
      if (line_wrap) begin
        src_col <= '0;
        out_col <= '0;
        if (frame_wrap) begin
          src_row <= '0;
          out_row <= '0;
        end else begin
          src_row <= src_row_inc[HGT_W-1:0];
          if (row_close) out_row <= out_row_inc[HGT_W-1:0];
        end
      end else begin
        src_col <= src_col_inc[WID_W-1:0];
        if (col_close) out_col <= out_col_inc[WID_W-1:0];
      end
    end
  end

  // column sum memory
  entry_t           mem [MAX_SRC_WIDTH];
  entry_t           rd_q, wr_data, sums_new;
  logic [AW-1:0]    col_addr, wr_addr, clr_addr;
  logic             wr_en;
  logic [PIX_W-1:0] pix_r, pix_g, pix_b;

  assign col_addr = ({2'b0, out_col} >= MAXW) ? AW'(MAX_SRC_WIDTH - 1) : AW'(out_col);

  always_ff @(posedge clk) begin
    if (rst || cfg_wr)        clr_addr <= '0;
    else if (cmd.clear_step)  clr_addr <= clr_addr + AW'(1);
  end

  always_comb begin
    sums_new.red   = rd_q.red   + SUM_W'(pix_r);
    sums_new.green = rd_q.green + SUM_W'(pix_g);
    sums_new.blue  = rd_q.blue  + SUM_W'(pix_b);
    sums_new.count = rd_q.count + CNT_W'(1);
    wr_en   = cmd.clear_step || cmd.calc_write || cmd.out_load;
    wr_addr = cmd.clear_step ? clr_addr : col_addr;
    wr_data = cmd.calc_write ? sums_new : '0;
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      rd_q  <= mem[col_addr];
      pix_r <= s_tdata[7:0];
      pix_g <= s_tdata[15:8];
      pix_b <= s_tdata[23:16];
    end
  end

  // divider operands: averages or next boundaries
  logic [LANES-1:0][SUM_W-1:0] div_num, div_q;
  logic [LANES-1:0][CNT_W-1:0] div_den;
  logic [CNT_W-1:0]            area;
  logic                        div_busy, div_done;

  assign area = (sums_new.count == '0) ? CNT_W'(1) : sums_new.count;

  always_comb begin
    if (cmd.avg_start) begin
      div_num = {sums_new.blue, sums_new.green, sums_new.red};
      div_den = {area, area, area};
    end else begin
      div_num[0] = SUM_W'(out_col_inc) * SUM_W'(sw_e);
      div_num[1] = SUM_W'(out_row_inc) * SUM_W'(sh_e);
      div_num[2] = '0;
      div_den[0] = CNT_W'(dw_e);
      div_den[1] = CNT_W'(dh_e);
      div_den[2] = CNT_W'(1);
    end
  end

  bxavg_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.avg_start || cmd.bnd_start),
    .dividend (div_num),
    .divisor  (div_den),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    if (rst || cfg_wr) begin
      col_end <= '0;
      row_end <= '0;
    end else if (cmd.bnd_load) begin
      col_end <= div_q[0][WID_W-1:0];
      row_end <= div_q[1][HGT_W-1:0];
    end
  end

  // canvas index and last flag, held while the averages are formed
  logic [IDX_W:0]   idx_full;
  logic [IDX_W-1:0] idx_q;
  logic             last_q;

  assign idx_full = (IDX_W+1)'({1'b0, out_row} + {1'b0, offset_y}) * (IDX_W+1)'(row_pitch)
                  + (IDX_W+1)'(out_col) + (IDX_W+1)'(offset_x);

  always_ff @(posedge clk) begin
    if (cmd.avg_start) begin
      idx_q  <= idx_full[IDX_W-1:0];
      last_q <= (out_col_inc >= {1'b0, dw_e}) && (out_row_inc >= {1'b0, dh_e});
    end
  end

  // output word
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      m_tdata <= {3'b0, div_q[2][PIX_W-1:0], div_q[1][PIX_W-1:0], div_q[0][PIX_W-1:0],
                  idx_q};
      m_tlast <= last_q;
    end
  end

  assign sts.cfg_wr     = cfg_wr;
  assign sts.emit       = col_close && row_close;
  assign sts.col_close  = col_close;
  assign sts.div_busy   = div_busy;
  assign sts.div_done   = div_done;
  assign sts.out_free   = !m_tvalid || m_tready;
  assign sts.clear_last = clr_addr == AW'(MAX_SRC_WIDTH - 1);

endmodule

// ===== rtl/bxavg_ctrl.sv =====
// Controller: sequences clearing, accumulation, averaging and boundary steps.
module bxavg_ctrl
  import bxavg_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [7:0] {
    S_CLEAR  = 8'b00000001,
    S_BSTART = 8'b00000010,
    S_BWAIT  = 8'b00000100,
    S_IDLE   = 8'b00001000,
    S_CALC   = 8'b00010000,
    S_AVG    = 8'b00100000,
    S_EMIT   = 8'b01000000,
    S_ADV    = 8'b10000000
  } state_t;

  state_t state, state_next;

  always_comb begin
    cmd        = '0;
    s_tready   = 1'b0;
    state_next = state;
    case (state)
      S_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (sts.clear_last) state_next = S_BSTART;
      end
      S_BSTART: begin
        cmd.bnd_start = 1'b1;
        state_next    = S_BWAIT;
      end
      S_BWAIT: begin
        if (sts.div_done) begin
          cmd.bnd_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      S_IDLE: begin
        s_tready   = 1'b1;
        cmd.accept = s_tvalid;
        if (s_tvalid) state_next = S_CALC;
      end
      S_CALC: begin
        if (sts.emit) begin
          cmd.avg_start = 1'b1;
          state_next    = S_AVG;
        end else begin
          cmd.calc_write = 1'b1;
          state_next     = S_ADV;
        end
      end
      S_AVG: begin
        if (sts.div_done) state_next = S_EMIT;
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_ADV;
        end
      end
      S_ADV: begin
        cmd.advance = 1'b1;
        state_next  = sts.col_close ? S_BSTART : S_IDLE;
      end
      default: state_next = S_CLEAR;
    endcase
    // a register write restarts the image
    if (sts.cfg_wr) state_next = S_CLEAR;
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_CLEAR;
    else     state <= state_next;
  end

  a_no_restart_busy: assert property (@(posedge clk) disable iff (rst)
    (cmd.avg_start || cmd.bnd_start) |-> !sts.div_busy)
    else $error("divider started while busy");

  a_cfg_clears: assert property (@(posedge clk) disable iff (rst)
    sts.cfg_wr |=> state == S_CLEAR)
    else $error("register write did not restart the image");

  a_out_slot: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> sts.out_free)
    else $error("output word overwritten");

  a_done_waited: assert property (@(posedge clk) disable iff (rst)
    sts.div_done |-> (state == S_AVG || state == S_BWAIT || sts.cfg_wr ||
                      state == S_CLEAR))
    else $error("division finished with nobody waiting");

endmodule

// ===== tb/tb_box_average_downscaler_core.sv =====
// Self-checking bench for the box average downscaler core.
`timescale 1ns / 1ps

module tb_box_average_downscaler_core;
  import bxavg_pkg::*;

  localparam int MAXW = 1280;
  localparam int MAXH = 960;

  // One destination pixel as it leaves the block
  typedef struct {
    logic [IDX_W-1:0] index;
    logic [7:0]       red;
    logic [7:0]       green;
    logic [7:0]       blue;
    logic             done;
  } dst_pixel_t;

  // Directed row: one source pixel, with an optional typed-in result
  typedef struct {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    bit         has_fixed;
    dst_pixel_t fixed;
  } src_row_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [IN_W-1:0]   s_tdata = '0;  // in_red, in_green, in_blue
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [OUT_W-1:0]  m_tdata;       // canvas_index, out_red, out_green, out_blue, zero pad
  logic              m_tlast;       // image_done
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  box_average_downscaler_core u_top (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow of the scaler: registers, column sums and raster position
  logic [10:0] regv [NUM_REGS];
  logic [28:0] sum_r [MAXW];
  logic [28:0] sum_g [MAXW];
  logic [28:0] sum_b [MAXW];
  logic [20:0] cnt_a [MAXW];
  int unsigned src_col, src_row, dst_col, dst_row, col_end, row_end;

  dst_pixel_t pending_pixels[$];
  int         errors = 0;
  int         words_in = 0;
  int         words_out = 0;
  int         images_done = 0;
  bit         hold_sink = 1'b0;
  int         hold_cycles = 0;

  function automatic int unsigned clamp_sz(int unsigned v, int unsigned hi);
    if (v == 0) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic int unsigned src_w();
    return clamp_sz(regv[REG_SRC_WIDTH], MAXW);
  endfunction
  function automatic int unsigned src_h();
    return clamp_sz(regv[REG_SRC_HEIGHT], MAXH);
  endfunction
  function automatic int unsigned dst_w();
    return clamp_sz(regv[REG_DST_WIDTH], src_w());
  endfunction
  function automatic int unsigned dst_h();
    return clamp_sz(regv[REG_DST_HEIGHT], src_h());
  endfunction

  function automatic int unsigned edge_of(int unsigned k, int unsigned s, int unsigned d);
    return (k * s) / d;
  endfunction

  // Abort the image: clear every column and rewind the raster
  function automatic void rewind_image();
    for (int i = 0; i < MAXW; i++) begin
      sum_r[i] = '0; sum_g[i] = '0; sum_b[i] = '0; cnt_a[i] = '0;
    end
    src_col = 0; src_row = 0; dst_col = 0; dst_row = 0;
    col_end = edge_of(1, src_w(), dst_w());
    row_end = edge_of(1, src_h(), dst_h());
  endfunction

  // Fold one source pixel into its column; return the destination pixel it closes
  function automatic bit fold_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b,
                                    output dst_pixel_t px);
    int unsigned sw, sh, dw, dh, c, cnt;
    longint unsigned idx;
    bit          got;
    sw = src_w(); sh = src_h(); dw = dst_w(); dh = dst_h();
    c = (dst_col >= MAXW) ? MAXW - 1 : dst_col;
    got = 1'b0;
    px = '{default: '0};
    sum_r[c] = sum_r[c] + r;
    sum_g[c] = sum_g[c] + g;
    sum_b[c] = sum_b[c] + b;
    cnt_a[c] = cnt_a[c] + 1;
    if (src_col + 1 >= col_end) begin
      if (src_row + 1 >= row_end) begin
        cnt = (cnt_a[c] != 0) ? cnt_a[c] : 1;
        idx = (longint'(dst_row) + regv[REG_OFFSET_Y]) * regv[REG_STRIDE]
              + dst_col + regv[REG_OFFSET_X];
        px.index = idx[IDX_W-1:0];
        px.red   = 8'(sum_r[c] / cnt);
        px.green = 8'(sum_g[c] / cnt);
        px.blue  = 8'(sum_b[c] / cnt);
        px.done  = (dst_col + 1 >= dw) && (dst_row + 1 >= dh);
        sum_r[c] = '0; sum_g[c] = '0; sum_b[c] = '0; cnt_a[c] = '0;
        got = 1'b1;
      end
      dst_col++;
      col_end = edge_of(dst_col + 1, sw, dw);
    end
    if (src_col + 1 >= sw) begin
      src_col = 0;
      dst_col = 0;
      col_end = edge_of(1, sw, dw);
      if (src_row + 1 >= row_end) begin
        dst_row++;
        row_end = edge_of(dst_row + 1, sh, dh);
      end
      src_row++;
      if (src_row >= sh) begin
        src_row = 0; dst_row = 0;
        row_end = edge_of(1, sh, dh);
      end
    end else begin
      src_col++;
    end
    return got;
  endfunction

  task automatic idle_cycles(int n);
    repeat (n) @(negedge clk);
  endtask

  // Drop the source, wait for every queued pixel, then let the block settle
  task automatic drain();
    s_tvalid <= 1'b0;
    wait (pending_pixels.size() == 0);
    idle_cycles(80);
  endtask

  // Setup then access phase; the register takes the value at the access edge
  task automatic write_reg(logic [2:0] which, logic [10:0] value);
    @(negedge clk);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= ADDR_W'({which, 2'b00}); pwdata <= DATA_W'(value);
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (which)
      REG_SRC_HEIGHT, REG_DST_HEIGHT, REG_OFFSET_Y: regv[which] = {1'b0, value[9:0]};
      default:                                      regv[which] = value;
    endcase
    rewind_image();
  endtask

  task automatic set_geometry(int sw, int sh, int dw, int dh, int stride, int ox, int oy);
    write_reg(REG_SRC_WIDTH, 11'(sw));
    write_reg(REG_SRC_HEIGHT, 11'(sh));
    write_reg(REG_DST_WIDTH, 11'(dw));
    write_reg(REG_DST_HEIGHT, 11'(dh));
    write_reg(REG_STRIDE, 11'(stride));
    write_reg(REG_OFFSET_X, 11'(ox));
    write_reg(REG_OFFSET_Y, 11'(oy));
  endtask

  // Offer one word after the given gap; the prediction is made at acceptance
  task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b, int gap,
                            bit has_fixed = 1'b0, dst_pixel_t fixed = '{default: '0});
    dst_pixel_t px;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      idle_cycles(gap);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {b, g, r};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    if (fold_pixel(r, g, b, px)) begin
      if (has_fixed) px = fixed;
      pending_pixels.push_back(px);
    end
    words_in++;
    @(negedge clk);
  endtask

  function automatic int pick_gap();
    return ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
  endfunction

  // Sink: random stalls per word, a long hold on request, field-by-field compare
  initial begin
    dst_pixel_t want;
    int         gap;
    forever begin
      @(negedge clk);
      if (hold_sink) begin
        m_tready <= 1'b0;
        repeat (hold_cycles) @(negedge clk);
        hold_sink = 1'b0;
      end
      m_tready <= 1'b1;
      @(posedge clk);
      if (m_tvalid && m_tready && !rst) begin
        words_out++;
        if (pending_pixels.size() == 0) begin
          $error("unexpected word: index %0d", m_tdata[20:0]);
          errors++;
        end else begin
          want = pending_pixels.pop_front();
          if (m_tdata[20:0] !== want.index) begin
            $error("canvas_index: expected %0d, got %0d", want.index, m_tdata[20:0]);
            errors++;
          end
          if (m_tdata[28:21] !== want.red) begin
            $error("out_red: expected %0d, got %0d", want.red, m_tdata[28:21]);
            errors++;
          end
          if (m_tdata[36:29] !== want.green) begin
            $error("out_green: expected %0d, got %0d", want.green, m_tdata[36:29]);
            errors++;
          end
          if (m_tdata[44:37] !== want.blue) begin
            $error("out_blue: expected %0d, got %0d", want.blue, m_tdata[44:37]);
            errors++;
          end
          if (m_tlast !== want.done) begin
            $error("image_done: expected %0d, got %0d", want.done, m_tlast);
            errors++;
          end
          if (want.done) images_done++;
        end
        gap = pick_gap();
        if (gap > 0) begin
          @(negedge clk);
          m_tready <= 1'b0;
          idle_cycles(gap - 1);
        end
      end
    end
  end

  // Directed rows; the first three run with the reset geometry of 1x1
  src_row_t directed_rows[$];

  task automatic add_row(logic [7:0] r, logic [7:0] g, logic [7:0] b, bit fixed_ok = 1'b0,
                         dst_pixel_t fixed = '{default: '0});
    directed_rows.push_back('{r, g, b, fixed_ok, fixed});
  endtask

  task automatic send_random_image(int n);
    for (int i = 0; i < n; i++)
      send_pixel(8'($urandom), 8'($urandom), 8'($urandom), pick_gap());
  endtask

  initial begin
    int sw, sh, dw, dh;
    for (int i = 0; i < NUM_REGS; i++) regv[i] = (i < 5) ? 11'd1 : 11'd0;
    rewind_image();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // After reset every pixel is its own 1x1 image at index 0
    add_row(8'd0, 8'd0, 8'd0, 1'b1, '{21'd0, 8'd0, 8'd0, 8'd0, 1'b1});
    add_row(8'd255, 8'd255, 8'd255, 1'b1, '{21'd0, 8'd255, 8'd255, 8'd255, 1'b1});
    add_row(8'hAA, 8'h55, 8'h0F, 1'b1, '{21'd0, 8'hAA, 8'h55, 8'h0F, 1'b1});
    foreach (directed_rows[i])
      send_pixel(directed_rows[i].r, directed_rows[i].g, directed_rows[i].b, pick_gap(),
                 directed_rows[i].has_fixed, directed_rows[i].fixed);
    drain();

    // 4x3 down to 3x2 with uneven boxes, extreme colours
    set_geometry(4, 3, 3, 2, 7, 2, 1);
    for (int i = 0; i < 12; i++)
      send_pixel((i % 2) ? 8'd255 : 8'd0, 8'(i * 20), (i % 3) ? 8'd255 : 8'd1, pick_gap());
    drain();

    // Zero sizes used as one, upscale request clamped, offsets that wrap the index
    set_geometry(0, 0, 0, 0, 2047, 2047, 1023);
    send_pixel(8'd17, 8'd34, 8'd51, 0);
    drain();
    set_geometry(3, 2, 9, 9, 2047, 2047, 1023);
    send_random_image(6);
    drain();

    // Abort mid-image by a register write, then a full image
    set_geometry(5, 4, 2, 2, 100, 3, 3);
    send_random_image(7);
    drain();
    write_reg(REG_OFFSET_X, 11'd9);
    send_random_image(20);
    drain();

    // Long sink hold, spanning the clearing pass, while the source keeps offering
    set_geometry(2, 2, 2, 2, 4, 0, 0);
    hold_cycles = 3000;
    hold_sink = 1'b1;
    send_random_image(40);
    drain();

    // Random geometries, mostly small images, each run to its end
    while (words_in < 800) begin
      sw = $urandom_range(1, 16);
      sh = $urandom_range(1, 12);
      dw = $urandom_range(1, sw);
      dh = $urandom_range(1, sh);
      set_geometry(sw, sh, dw, dh, $urandom_range(1, 2047), $urandom_range(0, 2047),
                   $urandom_range(0, 1023));
      send_random_image(sw * sh * $urandom_range(1, 2));
      if ($urandom_range(0, 3) == 0) drain();
      drain();
    end

    // Oversized width clamped to the source maximum, start of one row band
    set_geometry(2047, 1, 2047, 1, 1280, 0, 0);
    send_random_image(200);
    drain();

    $display("covered %0d source words, %0d destination words, %0d full images",
             words_in, words_out, images_done);
    if (errors == 0) begin
      $display("tb_box_average_downscaler_core: done, clean");
    end else begin
      $display("tb_box_average_downscaler_core: done, errors");
    end
    $finish;
  end

  // Runaway guard
  initial begin
    #20ms;
    $display("tb_box_average_downscaler_core: done, errors");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/bxavg_pkg.sv
rtl/bxavg_div.sv
rtl/bxavg_datapath.sv
rtl/bxavg_ctrl.sv
rtl/box_average_downscaler_core.sv
tb/tb_box_average_downscaler_core.sv
